FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LPP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpp assertion failed");

// Next-cycle implication, disabled during reset
`define LPP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpp assertion failed");

`endif

FILE: src/lpp_pkg.sv
// Package for the lidar packet to points block: types, constants, helper functions.
// No dependencies.
`timescale 1ns / 1ps

package lpp_pkg;

  localparam logic [67:0] ONE68 = 68'd1;

  // Header bytes and angle constants
  localparam logic [7:0]  HDR0 = 8'hA5;
  localparam logic [7:0]  HDR1 = 8'h5A;
  localparam logic [7:0]  HDR2 = 8'h3A;
  localparam logic [5:0]  BODY_LAST = 6'd54;
  localparam logic [16:0] FULL_TURN = 17'd36000;
  localparam logic [19:0] TURN15 = 20'd540000;
  localparam logic [19:0] QUARTER15 = 20'd135000;
  localparam logic [19:0] EIGHTH15 = 20'd67500;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // floor(a/15) as (a*K15) >> 24
  localparam logic [33:0] K15 = 34'(((ONE68 << 24) + 68'd14) / 68'd15);
  // theta = u*Q_TH + floor(u*R_TH / 135000); the division as (y*KD) >> 51
  localparam logic [33:0] Q_TH = 34'd12493;
  localparam logic [33:0] R_TH = 34'd74713;
  localparam logic [33:0] KD = 34'(((ONE68 << 51) + 68'd134999) / 68'd135000);

  // Taylor term divisors as reciprocals: ceil(2^m / d)
  localparam logic [33:0] RS1 = 34'(((ONE68 << 33) + 68'd5) / 68'd6);
  localparam logic [33:0] RS2 = 34'(((ONE68 << 35) + 68'd19) / 68'd20);
  localparam logic [33:0] RS3 = 34'(((ONE68 << 36) + 68'd41) / 68'd42);
  localparam logic [33:0] RS4 = 34'(((ONE68 << 37) + 68'd71) / 68'd72);
  localparam logic [33:0] RS5 = 34'(((ONE68 << 37) + 68'd109) / 68'd110);
  localparam logic [33:0] RS6 = 34'(((ONE68 << 38) + 68'd155) / 68'd156);
  localparam logic [33:0] RS7 = 34'(((ONE68 << 38) + 68'd209) / 68'd210);
  localparam logic [33:0] RC1 = 34'(((ONE68 << 31) + 68'd1) / 68'd2);
  localparam logic [33:0] RC2 = 34'(((ONE68 << 34) + 68'd11) / 68'd12);
  localparam logic [33:0] RC3 = 34'(((ONE68 << 35) + 68'd29) / 68'd30);
  localparam logic [33:0] RC4 = 34'(((ONE68 << 36) + 68'd55) / 68'd56);
  localparam logic [33:0] RC5 = 34'(((ONE68 << 37) + 68'd89) / 68'd90);
  localparam logic [33:0] RC6 = 34'(((ONE68 << 38) + 68'd131) / 68'd132);
  localparam logic [33:0] RC7 = 34'(((ONE68 << 38) + 68'd181) / 68'd182);

  typedef struct packed {
    logic [15:0] open_angle;
    logic [15:0] close_angle;
  } pkt_t;

  typedef struct packed {
    logic [33:0] mult;
    logic [5:0]  shift;
  } recip_t;

  function automatic recip_t taylor_recip(input logic cos_sel, input logic [2:0] k);
    recip_t r;
    r.mult = '0;
    r.shift = '0;
    case ({cos_sel, k})
      4'b0001: begin r.mult = RS1; r.shift = 6'd33; end
      4'b0010: begin r.mult = RS2; r.shift = 6'd35; end
      4'b0011: begin r.mult = RS3; r.shift = 6'd36; end
      4'b0100: begin r.mult = RS4; r.shift = 6'd37; end
      4'b0101: begin r.mult = RS5; r.shift = 6'd37; end
      4'b0110: begin r.mult = RS6; r.shift = 6'd38; end
      4'b0111: begin r.mult = RS7; r.shift = 6'd38; end
      4'b1001: begin r.mult = RC1; r.shift = 6'd31; end
      4'b1010: begin r.mult = RC2; r.shift = 6'd34; end
      4'b1011: begin r.mult = RC3; r.shift = 6'd35; end
      4'b1100: begin r.mult = RC4; r.shift = 6'd36; end
      4'b1101: begin r.mult = RC5; r.shift = 6'd37; end
      4'b1110: begin r.mult = RC6; r.shift = 6'd38; end
      4'b1111: begin r.mult = RC7; r.shift = 6'd38; end
      default: begin r.mult = '0; r.shift = '0; end
    endcase
    return r;
  endfunction

  // round(prod / 2^30), ties away from zero, saturate to 65535, apply sign
  function automatic logic signed [16:0] coord_round(input logic [47:0] prod,
                                                      input logic neg);
    logic [48:0] sum;
    logic [18:0] q;
    logic [16:0] mag;
    sum = {1'b0, prod} + 49'h0_2000_0000;
    q = sum[48:30];
    mag = (q > 19'd65535) ? 17'd65535 : q[16:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Reduce a captured angle below one full turn
  function automatic logic [15:0] angle_wrap(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} - FULL_TURN;
    return ({1'b0, v} >= FULL_TURN) ? t[15:0] : v;
  endfunction

endpackage

FILE: src/lpp_mul.sv
// Shared 34x34 unsigned multiplier with registered product.
// Depends on nothing.
`timescale 1ns / 1ps

module lpp_mul (
  input  logic        clk,
  input  logic [33:0] op_a,
  input  logic [33:0] op_b,
  output logic [67:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

FILE: src/lpp_parser.sv
// Header hunt and packet body capture into the sample store.
// Depends on lpp_pkg.
`timescale 1ns / 1ps

module lpp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               take,
  output logic               go,
  output lpp_pkg::pkt_t      pkt,
  input  logic [3:0]         rd_idx,
  output logic [23:0]        rd_data
);
  import lpp_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_A5   = 2'd1;
  localparam logic [1:0] PH_5A   = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic [1:0]  sync_phase;
  logic [5:0]  body_position;
  logic [3:0]  smp_idx;
  logic [1:0]  smp_sub;
  logic [7:0]  hi_byte;
  logic [15:0] open_ang;
  logic [15:0] close_ang;
  logic [23:0] sample_store [16];

  assign go = take && (sync_phase == PH_BODY) && (body_position == BODY_LAST);
  assign pkt = {open_ang, close_ang};
  assign rd_data = sample_store[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_phase <= PH_HUNT;
      body_position <= '0;
      smp_idx <= '0;
      smp_sub <= '0;
      open_ang <= '0;
      close_ang <= '0;
    end else if (take) begin
      case (sync_phase)
        PH_HUNT: begin
          if (rx_byte == HDR0) sync_phase <= PH_A5;
        end
        PH_A5: begin
          sync_phase <= (rx_byte == HDR1) ? PH_5A : PH_HUNT;
        end
        PH_5A: begin
          if (rx_byte == HDR2) begin
            sync_phase <= PH_BODY;
            body_position <= '0;
            smp_idx <= '0;
            smp_sub <= '0;
          end else begin
            sync_phase <= PH_HUNT;
          end
        end
        default: begin
          if (body_position == 6'd3) open_ang <= angle_wrap({hi_byte, rx_byte});
          if (body_position == 6'd53) close_ang <= angle_wrap({hi_byte, rx_byte});
          if (body_position >= 6'd4 && body_position <= 6'd51) begin
            smp_sub <= (smp_sub == 2'd2) ? 2'd0 : smp_sub + 2'd1;
            if (smp_sub == 2'd2) smp_idx <= smp_idx + 4'd1;
          end
          if (body_position == BODY_LAST) begin
            sync_phase <= PH_HUNT;
            body_position <= '0;
          end else begin
            body_position <= body_position + 6'd1;
          end
        end
      endcase
    end
  end

  // High angle byte and sample bytes carry no reset
  always_ff @(posedge clk) begin
    if (take && sync_phase == PH_BODY) begin
      if (body_position == 6'd2 || body_position == 6'd52) hi_byte <= rx_byte;
      if (body_position >= 6'd4 && body_position <= 6'd51) begin
        case (smp_sub)
          2'd0:    sample_store[smp_idx][23:16] <= rx_byte;
          2'd1:    sample_store[smp_idx][15:8] <= rx_byte;
          default: sample_store[smp_idx][7:0] <= rx_byte;
        endcase
      end
    end
  end

endmodule

FILE: src/lpp_engine.sv
// Point sequencer: angle interpolation, Taylor sine/cosine and coordinate scaling
// on one shared multiplier. Depends on lpp_pkg and lpp_mul.
`timescale 1ns / 1ps

module lpp_engine #(
  parameter int POINTS_PER_LINE = 512,
  parameter int LINE_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  lpp_pkg::pkt_t       pkt,
  output logic [3:0]          rd_idx,
  input  logic [23:0]         rd_data,
  output logic                busy,
  output logic [15:0]         angle_centideg,
  output logic [15:0]         distance,
  output logic signed [16:0]  x_coord,
  output logic signed [16:0]  y_coord,
  output logic [3:0]          line_index,
  output logic [8:0]          column_index,
  output logic [7:0]          intensity,
  output logic                last_point,
  output logic                out_valid,
  input  logic                out_stall
);
  import lpp_pkg::*;

  localparam int CW = (POINTS_PER_LINE > 1) ? $clog2(POINTS_PER_LINE) : 1;
  localparam int LW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FOLD = 4'd1;
  localparam logic [3:0] ST_TH1  = 4'd2;
  localparam logic [3:0] ST_TH2  = 4'd3;
  localparam logic [3:0] ST_TH3  = 4'd4;
  localparam logic [3:0] ST_TH4  = 4'd5;
  localparam logic [3:0] ST_SQ   = 4'd6;
  localparam logic [3:0] ST_SQ2  = 4'd7;
  localparam logic [3:0] ST_SM   = 4'd8;
  localparam logic [3:0] ST_SD   = 4'd9;
  localparam logic [3:0] ST_CM   = 4'd10;
  localparam logic [3:0] ST_CD   = 4'd11;
  localparam logic [3:0] ST_XM   = 4'd12;
  localparam logic [3:0] ST_XY   = 4'd13;
  localparam logic [3:0] ST_YR   = 4'd14;
  localparam logic [3:0] ST_WAIT = 4'd15;

  logic [3:0]         state;
  logic [19:0]        acc_a;
  logic [15:0]        dif;
  logic [3:0]         pt_idx;
  logic [1:0]         quad;
  logic               swap;
  logic [16:0]        u;
  logic [29:0]        th_part;
  logic [29:0]        theta;
  logic [29:0]        th2;
  logic [29:0]        ts;
  logic [30:0]        tc;
  logic signed [32:0] ss;
  logic signed [32:0] cc;
  logic [2:0]         term_k;
  logic [31:0]        sin_mag;
  logic               sin_neg;
  logic               cos_neg;
  logic [CW-1:0]      column_count;
  logic [LW-1:0]      line_count;

  logic [33:0] mul_a;
  logic [33:0] mul_b;
  logic [67:0] prod;

  logic [1:0]  fold_q;
  logic [19:0] fold_r;
  logic [19:0] step_sum;
  logic [16:0] dif_raw;
  recip_t      rs;
  recip_t      rc;
  logic [67:0] sh_s;
  logic [67:0] sh_c;
  logic signed [32:0] s0, c0, s1, c1;
  logic [32:0] cmag;
  logic [32:0] smag;
  logic [CW+8:0] col_ext;
  logic [LW+3:0] line_ext;

  lpp_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign busy = (state != ST_IDLE);
  assign rd_idx = pt_idx;
  assign rs = taylor_recip(1'b0, term_k);
  assign rc = taylor_recip(1'b1, term_k);
  assign sh_s = prod >> rs.shift;
  assign sh_c = prod >> rc.shift;
  assign col_ext = {9'd0, column_count};
  assign line_ext = {4'd0, line_count};

  // Fold the angle into quadrant and octant
  always_comb begin
    if (acc_a >= 20'd405000) begin
      fold_q = 2'd3;
      fold_r = acc_a - 20'd405000;
    end else if (acc_a >= 20'd270000) begin
      fold_q = 2'd2;
      fold_r = acc_a - 20'd270000;
    end else if (acc_a >= QUARTER15) begin
      fold_q = 2'd1;
      fold_r = acc_a - QUARTER15;
    end else begin
      fold_q = 2'd0;
      fold_r = acc_a;
    end
  end

  assign step_sum = acc_a + {4'd0, dif};
  assign dif_raw = (pkt.close_angle >= pkt.open_angle)
                 ? {1'b0, pkt.close_angle} - {1'b0, pkt.open_angle}
                 : {1'b0, pkt.close_angle} + FULL_TURN - {1'b0, pkt.open_angle};

  // Map octant results to the full circle
  always_comb begin
    s0 = swap ? cc : ss;
    c0 = swap ? ss : cc;
    case (quad)
      2'd0: begin s1 = s0;  c1 = c0;  end
      2'd1: begin s1 = c0;  c1 = -s0; end
      2'd2: begin s1 = -s0; c1 = -c0; end
      default: begin s1 = -c0; c1 = s0; end
    endcase
    cmag = c1[32] ? -c1 : c1;
    smag = s1[32] ? -s1 : s1;
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_FOLD: begin mul_a = 34'(acc_a); mul_b = K15; end
      ST_TH1:  begin mul_a = 34'(u); mul_b = Q_TH; end
      ST_TH2:  begin mul_a = 34'(u); mul_b = R_TH; end
      ST_TH3:  begin mul_a = 34'(prod[32:0]); mul_b = KD; end
      ST_SQ:   begin mul_a = 34'(theta); mul_b = 34'(theta); end
      ST_SQ2:  begin mul_a = 34'(theta); mul_b = 34'(prod[59:30]); end
      ST_SM:   begin mul_a = 34'(prod[59:30]); mul_b = rs.mult; end
      ST_SD:   begin mul_a = 34'(tc); mul_b = 34'(th2); end
      ST_CM:   begin mul_a = 34'(prod[59:30]); mul_b = rc.mult; end
      ST_CD:   begin mul_a = 34'(ts); mul_b = 34'(th2); end
      ST_XM:   begin mul_a = 34'(rd_data[23:8]); mul_b = 34'(cmag[31:0]); end
      ST_XY:   begin mul_a = 34'(rd_data[23:8]); mul_b = 34'(sin_mag); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      column_count <= '0;
      line_count <= '0;
      pt_idx <= '0;
      term_k <= '0;
    end else begin
      case (state)
        ST_IDLE: if (go) begin
          pt_idx <= '0;
          state <= ST_FOLD;
        end
        ST_FOLD: state <= ST_TH1;
        ST_TH1:  state <= ST_TH2;
        ST_TH2:  state <= ST_TH3;
        ST_TH3:  state <= ST_TH4;
        ST_TH4:  state <= ST_SQ;
        ST_SQ:   state <= ST_SQ2;
        ST_SQ2: begin
          term_k <= 3'd1;
          state <= ST_SM;
        end
        ST_SM:   state <= ST_SD;
        ST_SD:   state <= ST_CM;
        ST_CM:   state <= ST_CD;
        ST_CD: begin
          if (term_k == 3'd7) begin
            state <= ST_XM;
          end else begin
            term_k <= term_k + 3'd1;
            state <= ST_SM;
          end
        end
        ST_XM:   state <= ST_XY;
        ST_XY:   state <= ST_YR;
        ST_YR: begin
          out_valid <= 1'b1;
          state <= ST_WAIT;
        end
        default: begin
          // hold the request until the consumer takes it
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (column_count == CW'(POINTS_PER_LINE - 1)) begin
              column_count <= '0;
              line_count <= (line_count == LW'(LINE_COUNT - 1)) ? '0 : line_count + 1'b1;
            end else begin
              column_count <= column_count + 1'b1;
            end
            pt_idx <= pt_idx + 4'd1;
            state <= (pt_idx == 4'd15) ? ST_IDLE : ST_FOLD;
          end
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        acc_a <= {pkt.open_angle, 4'd0} - {4'd0, pkt.open_angle};
        dif <= dif_raw[15:0];
      end
      ST_FOLD: begin
        quad <= fold_q;
        swap <= (fold_r > EIGHTH15);
        u <= (fold_r > EIGHTH15) ? 17'(QUARTER15 - fold_r) : fold_r[16:0];
      end
      ST_TH1: angle_centideg <= prod[39:24];
      ST_TH2: th_part <= prod[29:0];
      ST_TH4: theta <= th_part + 30'(prod[67:51]);
      ST_SQ2: begin
        th2 <= prod[59:30];
        ts <= theta;
        tc <= ONE_Q30;
        ss <= $signed({3'd0, theta});
        cc <= $signed({2'd0, ONE_Q30});
      end
      ST_SD: begin
        ts <= sh_s[29:0];
        ss <= term_k[0] ? ss - $signed({3'd0, sh_s[29:0]})
                        : ss + $signed({3'd0, sh_s[29:0]});
      end
      ST_CD: begin
        tc <= {1'b0, sh_c[29:0]};
        cc <= term_k[0] ? cc - $signed({3'd0, sh_c[29:0]})
                        : cc + $signed({3'd0, sh_c[29:0]});
      end
      ST_XM: begin
        cos_neg <= c1[32];
        sin_neg <= s1[32];
        sin_mag <= smag[31:0];
      end
      ST_XY: x_coord <= coord_round(prod[47:0], cos_neg);
      ST_YR: begin
        y_coord <= coord_round(prod[47:0], sin_neg);
        distance <= rd_data[23:8];
        intensity <= rd_data[7:0];
        line_index <= line_ext[3:0];
        column_index <= col_ext[8:0];
        last_point <= (pt_idx == 4'd15);
      end
      ST_WAIT: begin
        if (!out_stall) begin
          acc_a <= (step_sum >= TURN15) ? step_sum - TURN15 : step_sum;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/lidar_packet_to_points.sv
// Lidar packet to points: takes serial bytes, finds the A5 5A 3A header, captures
// the 55-byte body (start angle, sixteen distance/intensity samples, end angle, all
// angles in centidegrees and reduced below 36000), and on the last body byte emits
// sixteen points with interpolated angle, distance, x = d*cos, y = d*sin, line and
// column position and intensity. Header and body bytes are taken one per cycle. After
// the last body byte the input stalls while the points are computed: each point runs
// through one shared 34x34 multiplier (angle divide, theta, seven Taylor terms for
// sine and cosine, two coordinate scalings) and then waits while the output is stalled.
// Column position wraps at POINTS_PER_LINE and then advances the line, which wraps
// at LINE_COUNT; the outputs show the low bits of each counter.
// Depends on lpp_pkg, lpp_parser, lpp_engine.
`timescale 1ns / 1ps

module lidar_packet_to_points #(
  parameter int POINTS_PER_LINE = 512,
  parameter int LINE_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               in_valid,
  output logic               in_stall,
  output logic [15:0]        angle_centideg,
  output logic [15:0]        distance,
  output logic signed [16:0] x_coord,
  output logic signed [16:0] y_coord,
  output logic [3:0]         line_index,
  output logic [8:0]         column_index,
  output logic [7:0]         intensity,
  output logic               last_point,
  output logic               out_valid,
  input  logic               out_stall
);
  import lpp_pkg::*;

  logic        busy;
  logic        take;
  logic        go;
  pkt_t        pkt;
  logic [3:0]  rd_idx;
  logic [23:0] rd_data;

  // Stall input requests while points of a packet are in flight
  assign in_stall = busy;
  assign take = in_valid && !busy;

  lpp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx_byte),
    .take    (take),
    .go      (go),
    .pkt     (pkt),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  lpp_engine #(
    .POINTS_PER_LINE (POINTS_PER_LINE),
    .LINE_COUNT      (LINE_COUNT)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .go             (go),
    .pkt            (pkt),
    .rd_idx         (rd_idx),
    .rd_data        (rd_data),
    .busy           (busy),
    .angle_centideg (angle_centideg),
    .distance       (distance),
    .x_coord        (x_coord),
    .y_coord        (y_coord),
    .line_index     (line_index),
    .column_index   (column_index),
    .intensity      (intensity),
    .last_point     (last_point),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

endmodule

FILE: src/lpp_checker.sv
// Port-level checker for the lidar packet to points block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic [15:0]        angle_centideg,
  input logic [15:0]        distance,
  input logic signed [16:0] x_coord,
  input logic signed [16:0] y_coord,
  input logic               out_valid,
  input logic               out_stall
);

  // Stalled result request keeps its x coordinate and distance
  `LPP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable({x_coord, distance}))
  // No byte is taken while a point waits
  `LPP_ASSERT_IMP(a_busy_out, out_valid, in_stall)
  // Angle stays below a full turn
  `LPP_ASSERT_IMP(a_angle_rng, out_valid, angle_centideg < 16'd36000)
  // Coordinates stay within the saturation bound
  `LPP_ASSERT_IMP(a_coord_rng, out_valid, x_coord != 17'h10000 && y_coord != 17'h10000)

endmodule

bind lidar_packet_to_points lpp_checker u_lpp_checker (.*);
